// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, reset on arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/nec_pkg.sv =====
// ----------------------------------------------------------------------------
// nec_pkg
// types, codes and timing constants of the nec ir frame decoder
// ----------------------------------------------------------------------------
package nec_pkg;

	localparam int CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_BURST_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MAX  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX   = 4'd7;

	localparam logic [2:0] PH_BURST    = 3'd0;
	localparam logic [2:0] PH_GAP      = 3'd1;
	localparam logic [2:0] PH_ADDR     = 3'd2;
	localparam logic [2:0] PH_ADDR_INV = 3'd3;
	localparam logic [2:0] PH_CMD      = 3'd4;
	localparam logic [2:0] PH_CMD_INV  = 3'd5;

	localparam logic [7:0] PULSE_MIN      = 8'd3;
	localparam logic [7:0] PULSE_MAX      = 8'd6;
	localparam logic [7:0] ZERO_MIN       = 8'd3;
	localparam logic [7:0] ZERO_MAX       = 8'd6;
	localparam logic [2:0] HOLD_OVERFLOWS = 3'd4;
	localparam logic [7:0] TICK_LAST      = 8'hff;

	typedef struct packed {
		logic [7:0] burst_min;
		logic [7:0] burst_max;
		logic [7:0] gap_min;
		logic [7:0] gap_max;
		logic [7:0] hold_min;
		logic [7:0] hold_max;
		logic [7:0] one_min;
		logic [7:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic [2:0] phase;
		logic [7:0] tick_count;
		logic       overflow_seen;
		logic [3:0] bit_index;
		logic [7:0] shift_byte;
		logic [7:0] pending_address;
		logic [7:0] pending_command;
		logic [7:0] held_address;
		logic [7:0] held_command;
		logic       hold_flag;
		logic       valid_flag;
		logic [2:0] hold_timeout;
	} dec_state_t;

	function automatic logic in_window(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

// ===== hdl/nec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// nec_cfg_regs
// timing window registers, written one beat at a time by index
// ----------------------------------------------------------------------------
module nec_cfg_regs import nec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst_min <= 8'd62;
			cfg_q.burst_max <= 8'd78;
			cfg_q.gap_min   <= 8'd31;
			cfg_q.gap_max   <= 8'd39;
			cfg_q.hold_min  <= 8'd15;
			cfg_q.hold_max  <= 8'd20;
			cfg_q.one_min   <= 8'd11;
			cfg_q.one_max   <= 8'd15;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BURST_MIN: cfg_q.burst_min <= cfg_data;
				CFG_BURST_MAX: cfg_q.burst_max <= cfg_data;
				CFG_GAP_MIN:   cfg_q.gap_min   <= cfg_data;
				CFG_GAP_MAX:   cfg_q.gap_max   <= cfg_data;
				CFG_HOLD_MIN:  cfg_q.hold_min  <= cfg_data;
				CFG_HOLD_MAX:  cfg_q.hold_max  <= cfg_data;
				CFG_ONE_MIN:   cfg_q.one_min   <= cfg_data;
				CFG_ONE_MAX:   cfg_q.one_max   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/nec_step.sv =====
// ----------------------------------------------------------------------------
// nec_step
// next-state logic of the decoder for one tick or one line edge
// ----------------------------------------------------------------------------
module nec_step import nec_pkg::*; (
	input  cfg_t       cfg,
	input  dec_state_t cur,
	input  logic       func,
	input  logic       line_level,
	output dec_state_t nxt,
	output logic       done
);

	logic [7:0] cnt;
	logic       bit_one;
	logic       bit_ok;
	logic [7:0] new_shift;
	logic [3:0] new_index;
	logic [7:0] inv;
	logic [2:0] tmo_dec;

	assign cnt     = cur.tick_count;
	assign tmo_dec = cur.hold_timeout - 3'd1;

	always_comb begin
		nxt       = cur;
		done      = 1'b0;
		bit_one   = in_window(cnt, cfg.one_min, cfg.one_max);
		bit_ok    = in_window(cnt, ZERO_MIN, ZERO_MAX) || bit_one;
		if (in_window(cnt, ZERO_MIN, ZERO_MAX)) begin
			bit_one = 1'b0;
		end
		new_shift = cur.shift_byte;
		new_shift[cur.bit_index[2:0]] = bit_one;
		new_index = cur.bit_index + 4'd1;
		inv       = ~new_shift;

		if (!func) begin
			if (cnt == TICK_LAST) begin
				nxt.tick_count    = 8'd0;
				nxt.overflow_seen = 1'b1;
				if (cur.hold_timeout != 3'd0) begin
					nxt.hold_timeout = tmo_dec;
					if (tmo_dec == 3'd0) begin
						nxt.hold_flag  = 1'b0;
						nxt.valid_flag = 1'b0;
					end
				end
			end else begin
				nxt.tick_count = cnt + 8'd1;
			end
		end else if (cur.overflow_seen) begin
			nxt.overflow_seen = 1'b0;
			nxt.phase         = PH_BURST;
			nxt.tick_count    = 8'd0;
		end else begin
			case (cur.phase)
				PH_GAP: begin
					nxt.phase = PH_BURST;
					if (!line_level) begin
						if (in_window(cnt, cfg.gap_min, cfg.gap_max)) begin
							nxt.phase      = PH_ADDR;
							nxt.shift_byte = 8'd0;
							nxt.bit_index  = 4'd0;
							nxt.hold_flag  = 1'b0;
							nxt.tick_count = 8'd0;
						end else if (in_window(cnt, cfg.hold_min, cfg.hold_max)
								&& cur.valid_flag) begin
							nxt.hold_flag    = 1'b1;
							nxt.hold_timeout = HOLD_OVERFLOWS;
						end
					end
				end
				PH_ADDR, PH_ADDR_INV, PH_CMD, PH_CMD_INV: begin
					if (line_level) begin
						if (in_window(cnt, PULSE_MIN, PULSE_MAX)) begin
							nxt.tick_count = 8'd0;
						end else begin
							nxt.phase = PH_BURST;
						end
					end else if (!bit_ok) begin
						nxt.phase = PH_BURST;
					end else begin
						nxt.shift_byte = new_shift;
						nxt.bit_index  = new_index;
						nxt.tick_count = 8'd0;
						if (new_index >= 4'd8) begin
							case (cur.phase)
								PH_ADDR: begin
									nxt.pending_address = new_shift;
									nxt.phase           = PH_ADDR_INV;
									nxt.bit_index       = 4'd0;
									nxt.shift_byte      = 8'd0;
								end
								PH_ADDR_INV: begin
									if (cur.pending_address != inv) begin
										nxt.phase = PH_BURST;
									end else begin
										nxt.phase      = PH_CMD;
										nxt.bit_index  = 4'd0;
										nxt.shift_byte = 8'd0;
									end
								end
								PH_CMD: begin
									nxt.pending_command = new_shift;
									nxt.phase           = PH_CMD_INV;
									nxt.bit_index       = 4'd0;
									nxt.shift_byte      = 8'd0;
								end
								default: begin
									nxt.phase = PH_BURST;
									if (cur.pending_command == inv) begin
										nxt.hold_timeout = HOLD_OVERFLOWS;
										nxt.held_address = cur.pending_address;
										nxt.held_command = cur.pending_command;
										nxt.valid_flag   = 1'b1;
										nxt.bit_index    = 4'd0;
										nxt.shift_byte   = 8'd0;
										done             = 1'b1;
									end
								end
							endcase
						end
					end
				end
				default: begin
					if (line_level) begin
						if (in_window(cnt, cfg.burst_min, cfg.burst_max)) begin
							nxt.phase      = PH_GAP;
							nxt.tick_count = 8'd0;
						end
					end else begin
						nxt.tick_count = 8'd0;
					end
				end
			endcase
		end
	end

endmodule

// ===== hdl/nec_ir_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// nec infrared frame decoder: ticks and line edges in, decoded status out
// ----------------------------------------------------------------------------
// Each input beat (a timer tick or a line edge) yields exactly one result
// beat. A beat is taken into an input register, the decoder state is updated
// from there and the result is registered in an output register together
// with the new state, and one beat is accepted every cycle while the output
// side keeps up; the update loop through the state register sets that rate.
// While a result waits in the output register the input register takes one
// more beat and then stalls. The config port is always ready and should be
// written only while no beats are in flight.
module nec_ir_frame_decoder_core import nec_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 frame_done,
	output logic [7:0]           address,
	output logic [7:0]           command,
	output logic                 key_hold,
	output logic                 signal_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

`include "assert_macros.svh"

	cfg_t       cfg;
	dec_state_t st_q;
	dec_state_t st_nxt;
	logic       step_done;
	logic       valid_s1;
	logic       func_s1;
	logic       level_s1;
	logic       advance;
	logic       data_phase;

	nec_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nec_step u_step (
		.cfg        (cfg),
		.cur        (st_q),
		.func       (func_s1),
		.line_level (level_s1),
		.nxt        (st_nxt),
		.done       (step_done)
	);

	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;

	assign data_phase = (st_q.phase >= PH_ADDR) && (st_q.phase <= PH_CMD_INV);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			level_s1 <= line_level;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_done   <= step_done;
			address      <= st_nxt.held_address;
			command      <= st_nxt.held_command;
			key_hold     <= st_nxt.hold_flag;
			signal_valid <= st_nxt.valid_flag;
		end
	end

	`ASSERT_IMPL(a_done_valid, out_valid && frame_done, signal_valid, "done without valid")
	`ASSERT_IMPL(a_hold_valid, st_q.hold_flag, st_q.valid_flag, "hold without valid")
	`ASSERT_IMPL(a_bit_index, data_phase, !st_q.bit_index[3], "bit index past byte")
	`ASSERT_NEXT(a_advance, advance, out_valid, "beat advanced but no result")

endmodule
